@@ hw/rtl/gha_pkg.sv @@
`timescale 1ns / 1ps

package gha_pkg;

   localparam int SLOT_COUNT_DEFAULT = 256;
   localparam int GEN_BITS_DEFAULT   = 8;

   // fixed field widths of the stream payloads
   localparam int MODE_W     = 2;
   localparam int HIDX_W     = 8;
   localparam int HGEN_W     = 8;
   localparam int STATUS_W   = 2;
   localparam int THR_W      = 9;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 24;

   localparam logic [THR_W-1:0] THR_RESET = 9'd32;

   // component bit positions within a slot entry
   localparam int COMP_W        = 3;
   localparam int COMP_PRIMARY  = 0;
   localparam int COMP_SCRIPT   = 1;
   localparam int COMP_GEOMETRY = 2;

   typedef enum logic [MODE_W-1:0] {
      MODE_CREATE = 2'd0,
      MODE_REMOVE = 2'd1,
      MODE_QUERY  = 2'd2
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK         = 2'd0,
      STATUS_NO_PRIMARY = 2'd1,
      STATUS_FULL       = 2'd2,
      STATUS_NOT_LIVE   = 2'd3
   } status_type;

   typedef enum logic {
      FSM_IDLE = 1'b0,
      FSM_EXEC = 1'b1
   } fsm_type;

   typedef struct packed {
      logic capture;
      logic execute;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } sts_type;

endpackage

@@ hw/rtl/generational_handle_allocator.sv @@
// Channel   Direction  Ports                     Payload
// req       in         req_tvalid/tready         tuser mode; tdata index, generation, flags
// rsp       out        rsp_tvalid/tready         tuser status; tdata index, generation, flags
// csr       in         csr_valid/ready/data      reuse threshold, always ready
//
// A transaction reads the slot and queue memories as it is taken in the idle state, then
// decides and writes them back in the execute state; no new request is taken meanwhile.
// The result is valid from the cycle after the write-back cycle.
// Reset clears fill count and queue pointers and loads a threshold of 32;
// memories need no clearing pass.
// A stalled result holds its register and blocks the next request until it is taken.
`timescale 1ns / 1ps

module generational_handle_allocator #(
   parameter int SLOT_COUNT      = gha_pkg::SLOT_COUNT_DEFAULT,
   parameter int GENERATION_BITS = gha_pkg::GEN_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // [7:0] handle_index, [15:8] handle_generation, [16] with_primary,
   // [17] want_script, [18] want_geometry, [23:19] zero
   input  logic [gha_pkg::REQ_DATA_W-1:0] req_tdata,
   // [1:0] mode
   input  logic [gha_pkg::MODE_W-1:0]     req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [7:0] out_index, [15:8] out_generation, [16] alive, [17] has_script,
   // [18] has_geometry, [23:19] zero
   output logic [gha_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // [1:0] status
   output logic [gha_pkg::STATUS_W-1:0]   rsp_tuser,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [gha_pkg::THR_W-1:0]      csr_data
);

   import gha_pkg::*;

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   gha_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   gha_datapath #(
      .SLOT_COUNT      (SLOT_COUNT),
      .GENERATION_BITS (GENERATION_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule

@@ hw/rtl/gha_ram.sv @@
`timescale 1ns / 1ps

module gha_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

@@ hw/rtl/gha_ctrl.sv @@
`timescale 1ns / 1ps

module gha_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  gha_pkg::sts_type sts,
   output gha_pkg::cmd_type cmd
);

   import gha_pkg::*;

   fsm_type state_ff;
   fsm_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FSM_IDLE: begin
            if (req_tvalid && sts.out_free) begin
               state_in = FSM_EXEC;
            end
         end
         FSM_EXEC: state_in = FSM_IDLE;
         default:  state_in = FSM_IDLE;
      endcase
   end

   always_comb begin
      req_tready  = 1'b0;
      cmd.capture = 1'b0;
      cmd.execute = 1'b0;
      case (state_ff)
         FSM_IDLE: begin
            // take a transaction only when the result slot is free by the next edge
            req_tready  = sts.out_free;
            cmd.capture = req_tvalid && sts.out_free;
         end
         FSM_EXEC: cmd.execute = 1'b1;
         default: ;
      endcase
   end

endmodule

@@ hw/rtl/gha_datapath.sv @@
`timescale 1ns / 1ps

module gha_datapath #(
   parameter int SLOT_COUNT      = gha_pkg::SLOT_COUNT_DEFAULT,
   parameter int GENERATION_BITS = gha_pkg::GEN_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [gha_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic [gha_pkg::MODE_W-1:0]      req_tuser,
   input  logic                            csr_valid,
   input  logic [gha_pkg::THR_W-1:0]       csr_data,
   output logic [gha_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic [gha_pkg::STATUS_W-1:0]    rsp_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  gha_pkg::cmd_type                cmd,
   output gha_pkg::sts_type                sts
);

   import gha_pkg::*;

   localparam int IDX_W = $clog2(SLOT_COUNT);
   localparam int CNT_W = $clog2(SLOT_COUNT + 1);
   localparam int GEN_W = GENERATION_BITS;
   localparam int CW    = (CNT_W > HIDX_W) ? CNT_W : HIDX_W;
   localparam int GW    = (GEN_W > HGEN_W) ? GEN_W : HGEN_W;
   localparam int TW    = (CNT_W > THR_W) ? CNT_W : THR_W;
   localparam int SLOT_W  = GEN_W + COMP_W;
   localparam int QUEUE_W = GEN_W + IDX_W;
   localparam logic [GEN_W-1:0] GEN_MAX = '1;

   // control state
   logic [THR_W-1:0] thr_ff;
   logic [CNT_W-1:0] slots_ff, slots_in;
   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] qcount_ff, qcount_in;
   logic             rsp_valid_ff;

   // captured transaction
   logic [MODE_W-1:0] mode_ff;
   logic [HIDX_W-1:0] hidx_ff;
   logic [HGEN_W-1:0] hgen_ff;
   logic              prim_ff, scr_ff, geo_ff;

   // result register
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [HIDX_W-1:0]   oidx_ff, oidx_in;
   logic [HGEN_W-1:0]   ogen_ff, ogen_in;
   logic                alive_ff, alive_in;
   logic                oscr_ff, oscr_in;
   logic                ogeo_ff, ogeo_in;

   // memories
   logic               slot_we;
   logic [IDX_W-1:0]   slot_waddr, slot_raddr, hidx_addr;
   logic [SLOT_W-1:0]  slot_wdata, slot_rdata;
   logic               q_we;
   logic [QUEUE_W-1:0] q_wdata, q_rdata;

   logic [GEN_W-1:0]  rd_gen;
   logic [COMP_W-1:0] rd_comp;
   logic [IDX_W-1:0]  new_idx;
   logic [GEN_W-1:0]  new_gen;
   logic              live, full, reuse;

   assign slot_raddr = IDX_W'(CW'(req_tdata[HIDX_W-1:0]));
   assign hidx_addr  = IDX_W'(CW'(hidx_ff));
   assign rd_gen     = slot_rdata[SLOT_W-1:COMP_W];
   assign rd_comp    = slot_rdata[COMP_W-1:0];

   gha_ram #(.WIDTH(SLOT_W), .DEPTH(SLOT_COUNT)) u_slot_ram (
      .clock (clock),
      .we    (slot_we),
      .waddr (slot_waddr),
      .wdata (slot_wdata),
      .raddr (slot_raddr),
      .rdata (slot_rdata)
   );

   gha_ram #(.WIDTH(QUEUE_W), .DEPTH(SLOT_COUNT)) u_queue_ram (
      .clock (clock),
      .we    (q_we),
      .waddr (tail_ff),
      .wdata (q_wdata),
      .raddr (head_ff),
      .rdata (q_rdata)
   );

   // slots beyond the fill count were never written, so gate on it first
   assign live  = (CW'(hidx_ff) < CW'(slots_ff)) && (GW'(rd_gen) == GW'(hgen_ff))
                  && rd_comp[COMP_PRIMARY];
   assign full  = (slots_ff == CNT_W'(SLOT_COUNT));
   assign reuse = (TW'(qcount_ff) > TW'(thr_ff)) || (full && (qcount_ff != '0));

   always_comb begin
      slots_in   = slots_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      qcount_in  = qcount_ff;
      slot_we    = 1'b0;
      slot_waddr = hidx_addr;
      slot_wdata = {rd_gen, COMP_W'(0)};
      q_we       = 1'b0;
      q_wdata    = {rd_gen, hidx_addr};
      new_idx    = IDX_W'(slots_ff);
      new_gen    = '0;
      status_in  = STATUS_OK;
      oidx_in    = hidx_ff;
      ogen_in    = hgen_ff;
      alive_in   = 1'b0;
      oscr_in    = 1'b0;
      ogeo_in    = 1'b0;
      case (mode_ff)
         MODE_CREATE: begin
            oidx_in = '0;
            ogen_in = '0;
            if (!prim_ff) begin
               status_in = STATUS_NO_PRIMARY;
            end else if (!reuse && full) begin
               status_in = STATUS_FULL;
            end else begin
               if (reuse) begin
                  new_idx   = q_rdata[IDX_W-1:0];
                  new_gen   = q_rdata[QUEUE_W-1:IDX_W] + GEN_W'(1);
                  head_in   = (head_ff == IDX_W'(SLOT_COUNT - 1)) ? '0 : head_ff + IDX_W'(1);
                  qcount_in = qcount_ff - CNT_W'(1);
               end else begin
                  slots_in  = slots_ff + CNT_W'(1);
               end
               slot_we    = cmd.execute;
               slot_waddr = new_idx;
               slot_wdata = {new_gen, geo_ff, scr_ff, 1'b1};
               oidx_in    = HIDX_W'(CW'(new_idx));
               ogen_in    = HGEN_W'(GW'(new_gen));
               alive_in   = 1'b1;
               oscr_in    = scr_ff;
               ogeo_in    = geo_ff;
            end
         end
         MODE_REMOVE: begin
            if (!live) begin
               status_in = STATUS_NOT_LIVE;
            end else begin
               // clear components, keep the generation
               slot_we = cmd.execute;
               if (rd_gen != GEN_MAX && qcount_ff != CNT_W'(SLOT_COUNT)) begin
                  q_we      = cmd.execute;
                  tail_in   = (tail_ff == IDX_W'(SLOT_COUNT - 1)) ? '0 : tail_ff + IDX_W'(1);
                  qcount_in = qcount_ff + CNT_W'(1);
               end
            end
         end
         default: begin
            alive_in = live;
            oscr_in  = live && rd_comp[COMP_SCRIPT];
            ogeo_in  = live && rd_comp[COMP_GEOMETRY];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff       <= THR_RESET;
         slots_ff     <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         qcount_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            thr_ff <= csr_data;
         end
         if (cmd.execute) begin
            slots_ff     <= slots_in;
            head_ff      <= head_in;
            tail_ff      <= tail_in;
            qcount_ff    <= qcount_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff <= req_tuser;
         hidx_ff <= req_tdata[HIDX_W-1:0];
         hgen_ff <= req_tdata[HIDX_W+HGEN_W-1:HIDX_W];
         prim_ff <= req_tdata[HIDX_W+HGEN_W];
         scr_ff  <= req_tdata[HIDX_W+HGEN_W+1];
         geo_ff  <= req_tdata[HIDX_W+HGEN_W+2];
      end
      if (cmd.execute) begin
         status_ff <= status_in;
         oidx_ff   <= oidx_in;
         ogen_ff   <= ogen_in;
         alive_ff  <= alive_in;
         oscr_ff   <= oscr_in;
         ogeo_ff   <= ogeo_in;
      end
   end

   assign sts.out_free = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tuser    = status_ff;
   assign rsp_tdata    = RSP_DATA_W'({ogeo_ff, oscr_ff, alive_ff, ogen_ff, oidx_ff});

   assert property (@(posedge clock) disable iff (reset)
      qcount_ff <= CNT_W'(SLOT_COUNT))
      else $error("retired queue count beyond capacity");

   assert property (@(posedge clock) disable iff (reset)
      (qcount_ff == '0 || qcount_ff == CNT_W'(SLOT_COUNT)) |-> (head_ff == tail_ff))
      else $error("queue pointers disagree with count");

   assert property (@(posedge clock) disable iff (reset)
      (TW'(qcount_ff) + TW'(0) <= TW'(slots_ff)))
      else $error("more retired handles than allocated slots");

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.execute))
      else $error("result raised without an execute cycle");

endmodule
